### design/rrbc_pkg.sv
`default_nettype none
package rrbc_pkg;

  localparam int RAM_OFFSET_W = 13;  // byte offset inside one 8 KiB RAM bank
  localparam int ROM_OFFSET_W = 14;  // byte offset inside one 16 KiB ROM bank
  localparam int ROM_BANK_W   = 7;
  localparam int ROM_ADDR_W   = ROM_BANK_W + ROM_OFFSET_W;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 8;

  localparam logic       REQ_READ  = 1'b0;
  localparam logic       REQ_WRITE = 1'b1;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS_BYTE  = 8'hFF;

  // Bus regions on address[15:13]
  localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
  localparam logic [2:0] REGION_LOW_BANK   = 3'd1;
  localparam logic [2:0] REGION_UPPER_BANK = 3'd2;
  localparam logic [2:0] REGION_MODE       = 3'd3;
  localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_MASK = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HAS_RAM       = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_MASK = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HAS_BATTERY   = 4'd3;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  wdata;
  } req_t;

  typedef struct packed {
    logic                    rom_fetch;
    logic [ROM_ADDR_W-1:0]   rom_address;
    logic                    ram_read;
    logic                    ram_we;
    logic [1:0]              ram_bank;
    logic [RAM_OFFSET_W-1:0] ram_offset;
    logic [7:0]              fixed_data;
    logic                    save_pending;
  } access_t;

endpackage
`default_nettype wire

### design/rrbc_ctrl.sv
`default_nettype none
module rrbc_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [rrbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rrbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             accept,
  input  wire rrbc_pkg::req_t                   req,
  output rrbc_pkg::access_t                     acc
);
  import rrbc_pkg::*;

  logic [ROM_BANK_W-1:0] rom_bank_mask;
  logic                  has_ram;
  logic [1:0]            ram_bank_mask;
  logic                  has_battery;

  logic [3:0] ram_enable_nibble, ram_enable_nibble_next;
  logic [4:0] low_rom_bank, low_rom_bank_next;
  logic [1:0] upper_bank_bits, upper_bank_bits_next;
  logic       banking_mode, banking_mode_next;
  logic       save_flag, save_flag_next;

  logic                  ram_active;
  logic [ROM_BANK_W-1:0] rom_bank_lo, rom_bank_hi;

  always_comb begin
    ram_enable_nibble_next = ram_enable_nibble;
    low_rom_bank_next      = low_rom_bank;
    upper_bank_bits_next   = upper_bank_bits;
    banking_mode_next      = banking_mode;
    save_flag_next         = save_flag;
    acc                    = '0;
    ram_active  = (ram_enable_nibble == RAM_ENABLE_KEY) && has_ram;
    rom_bank_lo = (banking_mode ? {upper_bank_bits, 5'b00000} : '0) & rom_bank_mask;
    rom_bank_hi = {upper_bank_bits, low_rom_bank} & rom_bank_mask;
    acc.ram_bank   = (banking_mode ? upper_bank_bits : 2'b00) & ram_bank_mask;
    acc.ram_offset = req.address[RAM_OFFSET_W-1:0];
    if (req.kind == REQ_WRITE) begin
      unique case (req.address[15:13])
        REGION_RAM_ENABLE: ram_enable_nibble_next = req.wdata[3:0];
        REGION_LOW_BANK:   low_rom_bank_next =
                             (req.wdata[4:0] == 5'd0) ? 5'd1 : req.wdata[4:0];
        REGION_UPPER_BANK: upper_bank_bits_next = req.wdata[1:0];
        REGION_MODE:       banking_mode_next = req.wdata[0];
        REGION_EXT_RAM: begin
          if (ram_active) begin
            acc.ram_we = 1'b1;
            if (has_battery) save_flag_next = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      if (!req.address[15]) begin
        acc.rom_fetch   = 1'b1;
        acc.rom_address = {req.address[14] ? rom_bank_hi : rom_bank_lo,
                           req.address[ROM_OFFSET_W-1:0]};
      end else if (req.address[15:13] == REGION_EXT_RAM && ram_active) begin
        acc.ram_read = 1'b1;
      end else begin
        acc.fixed_data = OPEN_BUS_BYTE;
      end
    end
    acc.save_pending = save_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_mask     <= 7'd1;
      has_ram           <= 1'b0;
      ram_bank_mask     <= 2'd0;
      has_battery       <= 1'b0;
      ram_enable_nibble <= 4'd0;
      low_rom_bank      <= 5'd1;
      upper_bank_bits   <= 2'd0;
      banking_mode      <= 1'b0;
      save_flag         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ROM_BANK_MASK: rom_bank_mask <= cfg_data[ROM_BANK_W-1:0];
          CFG_HAS_RAM:       has_ram       <= cfg_data[0];
          CFG_RAM_BANK_MASK: ram_bank_mask <= cfg_data[1:0];
          CFG_HAS_BATTERY:   has_battery   <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        ram_enable_nibble <= ram_enable_nibble_next;
        low_rom_bank      <= low_rom_bank_next;
        upper_bank_bits   <= upper_bank_bits_next;
        banking_mode      <= banking_mode_next;
        save_flag         <= save_flag_next;
      end
    end
  end

endmodule
`default_nettype wire

### design/rrbc_ram.sv
`default_nettype none
module rrbc_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else    rdata     <= mem[addr];
    end
  end

endmodule
`default_nettype wire

### design/rom_ram_bank_controller_type1.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  tuser: req_type; tdata: address, write_data
// m_*      out        m_tvalid / m_tready  tuser: rom_fetch;
//                                          tdata: rom_address, read_data, save_pending
// cfg_*    in         cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One bus transaction per cycle sustained while m_tready stays high; each result
// is held in the result stage beside the banked RAM read data, then in the
// output register.
// Reset (rst, synchronous) restores the bank and config registers and empties
// the pipeline; the RAM contents are not cleared and have no reset pass.
// A stalled output holds the result stage; s_tready drops only when both the
// result stage and the output register are full and m_tready is low.
module rom_ram_bank_controller_type1 #(
  parameter int RAM_BANKS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rrbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rrbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // bus requests
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [23:0]                      s_tdata,  // address[15:0], write_data[23:16]
  input  wire logic                             s_tuser,  // req_type
  // results
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [31:0]                           m_tdata,  // rom_address[20:0],
                                                          // read_data[28:21],
                                                          // save_pending[29], zero
  output logic                                  m_tuser   // rom_fetch
);
  import rrbc_pkg::*;

  localparam int RAM_BANK_BYTES = 1 << RAM_OFFSET_W;
  localparam int DEPTH = RAM_BANKS * RAM_BANK_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [2:0] BANK_COUNT = 3'(RAM_BANKS);

  req_t    req;
  access_t acc;
  access_t s1;
  logic    s1_valid;
  logic    accept, advance;
  logic [1:0]    ram_bank_wrap;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic [7:0]    read_byte;

  assign cfg_ready = 1'b1;

  assign req = {s_tuser, s_tdata[15:0], s_tdata[23:16]};

  // Move the result stage forward when the output register is free or draining.
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  rrbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req       (req),
    .acc       (acc)
  );

  // Wrap the bank number onto the fitted store, then form the byte index.
  // The bank is at most three, so three compare-and-subtract steps suffice.
  always_comb begin
    ram_bank_wrap = acc.ram_bank;
    for (int k = 0; k < 3; k++) begin
      if ({1'b0, ram_bank_wrap} >= BANK_COUNT) begin
        ram_bank_wrap = 2'({1'b0, ram_bank_wrap} - BANK_COUNT);
      end
    end
  end

  assign ram_addr = AW'({ram_bank_wrap, acc.ram_offset});

  // One RAM access per accepted transaction that decodes a RAM read or write; a read
  // after a write to the same byte lands in a later cycle, so the store already holds the new value.
  rrbc_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .en    (accept && (acc.ram_we || acc.ram_read)),
    .we    (acc.ram_we),
    .addr  (ram_addr),
    .wdata (req.wdata),
    .rdata (ram_rdata)
  );

  // Hold the transaction beside the RAM read data until it can advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1 <= acc;
  end

  assign read_byte = s1.ram_read ? ram_rdata : s1.fixed_data;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, s1.save_pending, read_byte, s1.rom_address};
      m_tuser <= s1.rom_fetch;
    end
  end

  // A full result stage behind a stalled output must block new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while result path is full");

  // A result stage that advances always shows up at the output next cycle.
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("advanced result missing at output");

  // The stored decode never marks a transaction as both RAM read and write.
  a_ram_one_op: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1.ram_read && s1.ram_we))
    else $error("RAM read and write decoded together");

endmodule
`default_nettype wire

### tb/rom_ram_bank_controller_type1_tb.sv
`default_nettype none
module rom_ram_bank_controller_type1_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrbc_pkg::*;

  // Abort the run well beyond the slowest legal pace: 865 transactions, each
  // at worst the longest sender gap plus the longest result stall and the pipeline
  // delay, plus the drains between phases.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          PHASE_ITEMS = 120;

  // One result transaction as the bus side sees it.
  typedef struct packed {
    logic                  fetch;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic [7:0]            rdata;
    logic                  save;
  } bank_result_t;

  // Mirror of the bank controller: configuration, bank registers, the banked
  // RAM and the FIFO of results still owed by the block.
  class bank_scoreboard;
    logic [ROM_BANK_W-1:0] rom_mask;
    logic                  ram_fitted;
    logic [1:0]            ram_mask;
    logic                  battery;
    logic [3:0]            enable_nibble;
    logic [4:0]            low_bank;
    logic [1:0]            upper_bits;
    logic                  mode;
    logic                  save_flag;
    logic [7:0]            ram_bytes [0:32767];
    bit                    written [0:32767];
    int unsigned           written_list [$];
    bank_result_t          owed_results [$];
    int                    mismatches;

    function new();
      rom_mask      = 1;
      ram_fitted    = 0;
      ram_mask      = 0;
      battery       = 0;
      enable_nibble = 0;
      low_bank      = 1;
      upper_bits    = 0;
      mode          = 0;
      save_flag     = 0;
      mismatches    = 0;
    endfunction

    function void set_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_ROM_BANK_MASK: rom_mask   = value[ROM_BANK_W-1:0];
        CFG_HAS_RAM:       ram_fitted = value[0];
        CFG_RAM_BANK_MASK: ram_mask   = value[1:0];
        CFG_HAS_BATTERY:   battery    = value[0];
        default: ;
      endcase
    endfunction

    function bit ram_active();
      return enable_nibble == RAM_ENABLE_KEY && ram_fitted;
    endfunction

    function logic [1:0] ram_bank();
      return (mode ? upper_bits : 2'b00) & ram_mask;
    endfunction

    function int unsigned ram_slot(logic [15:0] addr);
      return 32'({ram_bank(), addr[RAM_OFFSET_W-1:0]});
    endfunction

    function bit reads_unwritten(logic [15:0] addr);
      return addr[15:13] == REGION_EXT_RAM && ram_active() && !written[ram_slot(addr)];
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Apply one accepted bus transaction and queue the result it must produce.
    function void predict_access(logic kind, logic [15:0] addr, logic [7:0] data);
      bank_result_t          r;
      int unsigned           slot;
      logic [ROM_BANK_W-1:0] bank;
      r = '0;
      if (kind == REQ_WRITE) begin
        case (addr[15:13])
          REGION_RAM_ENABLE: enable_nibble = data[3:0];
          REGION_LOW_BANK:   low_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
          REGION_UPPER_BANK: upper_bits = data[1:0];
          REGION_MODE:       mode = data[0];
          REGION_EXT_RAM: begin
            if (ram_active()) begin
              slot = ram_slot(addr);
              ram_bytes[slot] = data;
              if (!written[slot]) begin
                written[slot] = 1'b1;
                written_list.insert(written_list.size(), slot);
              end
              if (battery) save_flag = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        case (addr[15:13])
          REGION_RAM_ENABLE, REGION_LOW_BANK: begin
            bank = (mode ? {upper_bits, 5'd0} : 7'd0) & rom_mask;
            r.fetch = 1'b1;
            r.rom_addr = {bank, addr[ROM_OFFSET_W-1:0]};
          end
          REGION_UPPER_BANK, REGION_MODE: begin
            bank = {upper_bits, low_bank} & rom_mask;
            r.fetch = 1'b1;
            r.rom_addr = {bank, addr[ROM_OFFSET_W-1:0]};
          end
          REGION_EXT_RAM: r.rdata = ram_active() ? ram_bytes[ram_slot(addr)] : OPEN_BUS_BYTE;
          default:        r.rdata = OPEN_BUS_BYTE;
        endcase
      end
      r.save = save_flag;
      owed_results.insert(owed_results.size(), r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_reply(logic fetch, logic [31:0] word);
      bank_result_t want;
      if (owed_results.size() == 0) begin
        report("unexpected result", word, 0);
        return;
      end
      want = owed_results.pop_front();
      if (fetch !== want.fetch)
        report("rom_fetch", 32'(fetch), 32'(want.fetch));
      if (word[20:0] !== want.rom_addr)
        report("rom_address", 32'(word[20:0]), 32'(want.rom_addr));
      if (word[28:21] !== want.rdata)
        report("read_data", 32'(word[28:21]), 32'(want.rdata));
      if (word[29] !== want.save)
        report("save_pending", 32'(word[29]), 32'(want.save));
      if (word[31:30] !== 2'b00)
        report("tdata padding", 32'(word[31:30]), 0);
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [23:0]            s_tdata;  // address[15:0], write_data[23:16]
  logic                   s_tuser;  // req_type
  logic                   m_tvalid;
  logic                   m_tready;
  logic [31:0]            m_tdata;  // rom_address[20:0], read_data[28:21], save_pending[29]
  logic                   m_tuser;  // rom_fetch

  bank_scoreboard sb = new();
  bit             calm = 1'b0;    // set for the closing phase: no gaps, no stalls
  int unsigned    cycle_count = 0;

  rom_ram_bank_controller_type1 dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rom_ram_bank_controller_type1_tb failed");
      $finish;
    end
  end

  // Check every result transaction against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata);
  end

  // Result-side backpressure: random stall bursts, none once the run is calm.
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Hold one request until the block takes it, then note it for prediction.
  // Reads of RAM cells never written are turned into writes of that cell.
  task automatic send_access(input logic kind, input logic [15:0] addr, input logic [7:0] data);
    logic k;
    k = kind;
    if (k == REQ_READ && sb.reads_unwritten(addr)) k = REQ_WRITE;
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {data, addr};
    do @(posedge clk); while (!s_tready);
    sb.predict_access(k, addr, data);
    // Insert a random sender gap after some transactions.
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drop the request valid and wait until every owed result has arrived,
  // then let the pipeline settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write all four configuration registers back to back; only while idle.
  task automatic program_cartridge(input logic [6:0] rom_mask, input logic fitted,
                                   input logic [1:0] ram_mask, input logic battery);
    logic [CFG_INDEX_W-1:0] idx [4];
    logic [CFG_DATA_W-1:0]  val [4];
    int                     i;
    idx = '{CFG_ROM_BANK_MASK, CFG_HAS_RAM, CFG_RAM_BANK_MASK, CFG_HAS_BATTERY};
    val = '{{1'b0, rom_mask}, {7'd0, fitted}, {6'd0, ram_mask}, {7'd0, battery}};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_config(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Pick one random access, weighted toward well-formed cartridge traffic:
  // ROM reads, bank register writes with a usable enable key, RAM writes and
  // reads back of written cells, plus some arbitrary bus noise.
  task automatic pick_access(output logic kind, output logic [15:0] addr,
                             output logic [7:0] data);
    int          sel;
    int          tries;
    int unsigned slot;
    kind = REQ_READ;
    addr = 16'($urandom);
    data = 8'($urandom);
    sel  = $urandom_range(0, 99);
    if (sel < 30) begin
      addr = 16'($urandom_range(0, 16'h7FFF));
    end else if (sel < 45) begin
      kind = REQ_WRITE;
      addr = 16'($urandom_range(0, 16'h7FFF));
      if (addr[15:13] == REGION_RAM_ENABLE && $urandom_range(0, 3) != 0)
        data[3:0] = RAM_ENABLE_KEY;
    end else if (sel < 70) begin
      kind = REQ_WRITE;
      addr = {REGION_EXT_RAM, 13'($urandom)};
    end else if (sel < 90) begin
      addr = {REGION_EXT_RAM, 13'($urandom)};
      if (sb.ram_active()) begin
        // Read back a written cell of the current bank; else write a new one.
        kind = REQ_WRITE;
        for (tries = 0; tries < 16 && sb.written_list.size() > 0; tries++) begin
          slot = sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
          if (slot[14:13] == sb.ram_bank()) begin
            kind = REQ_READ;
            addr = {REGION_EXT_RAM, slot[12:0]};
            break;
          end
        end
      end
    end else if ($urandom_range(0, 1) == 1) begin
      kind = REQ_WRITE;
    end
  endtask

  task automatic run_random(input int count);
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    repeat (count) begin
      pick_access(kind, addr, data);
      send_access(kind, addr, data);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tuser   <= REQ_READ;
    s_tdata   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: ROM bank mask of 1, no RAM, so RAM reads are open bus.
    send_access(REQ_READ,  16'h4000, 8'h00);
    send_access(REQ_READ,  16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'h0000, 8'h0A);
    send_access(REQ_READ,  16'hA000, 8'h00);
    send_access(REQ_WRITE, 16'hA000, 8'h5A);
    drain_results();

    // Largest ROM and RAM, no battery: bank edges, zero bank, mode switching.
    program_cartridge(7'd127, 1'b1, 2'd3, 1'b0);
    send_access(REQ_READ,  16'h0000, 8'h00);
    send_access(REQ_READ,  16'h3FFF, 8'h00);
    send_access(REQ_WRITE, 16'h2000, 8'h00);  // zero bank selects bank one
    send_access(REQ_READ,  16'h4000, 8'h00);
    send_access(REQ_WRITE, 16'h3FFF, 8'hFF);
    send_access(REQ_WRITE, 16'h5FFF, 8'hFF);
    send_access(REQ_READ,  16'h7FFF, 8'h00);
    send_access(REQ_WRITE, 16'h7FFF, 8'h01);  // mode 1: upper bits bank the low window
    send_access(REQ_READ,  16'h0000, 8'h00);
    send_access(REQ_WRITE, 16'hA000, 8'h00);
    send_access(REQ_WRITE, 16'hBFFF, 8'hFF);
    send_access(REQ_READ,  16'hA000, 8'h00);
    send_access(REQ_READ,  16'hBFFF, 8'h00);
    send_access(REQ_WRITE, 16'h1FFF, 8'hF5);  // wrong key disables RAM
    send_access(REQ_READ,  16'hBFFF, 8'h00);
    send_access(REQ_READ,  16'h8000, 8'h00);
    send_access(REQ_READ,  16'hFFFF, 8'h00);
    send_access(REQ_WRITE, 16'hC000, 8'hAA);
    send_access(REQ_WRITE, 16'h0000, 8'hFA);  // key lives in the low nibble only
    send_access(REQ_WRITE, 16'h6000, 8'hFE);
    drain_results();

    // Random phases, battery-backed settings last since the save flag sticks.
    program_cartridge(7'd1, 1'b0, 2'd0, 1'b0);
    run_random(PHASE_ITEMS);
    drain_results();
    program_cartridge(7'd3, 1'b1, 2'd1, 1'b0);
    run_random(PHASE_ITEMS);
    drain_results();
    program_cartridge(7'd127, 1'b1, 2'd3, 1'b0);
    run_random(PHASE_ITEMS);
    drain_results();
    program_cartridge(7'd127, 1'b1, 2'd0, 1'b1);
    run_random(PHASE_ITEMS);
    drain_results();
    repeat (2) begin
      program_cartridge(7'($urandom_range(1, 127)), 1'($urandom_range(0, 1)),
                        2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      run_random(PHASE_ITEMS);
      drain_results();
    end

    // Closing phase at full rate on both sides.
    program_cartridge(7'd15, 1'b1, 2'd2, 1'b1);
    calm = 1'b1;
    run_random(PHASE_ITEMS);
    drain_results();

    if (sb.pending() != 0) sb.report("results left over", sb.pending(), 0);
    if (sb.mismatches == 0) begin
      $display("rom_ram_bank_controller_type1_tb passed");
    end else begin
      $display("rom_ram_bank_controller_type1_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
design/rrbc_pkg.sv
design/rrbc_ctrl.sv
design/rrbc_ram.sv
design/rom_ram_bank_controller_type1.sv
tb/rom_ram_bank_controller_type1_tb.sv
